>>> rtl/core/rbpe_pkg.sv
// Shared types and constants for the RSA block packer and encryptor.
package rbpe_pkg;

   localparam int CodeW       = 14;
   localparam int CipherW     = 32;
   localparam int CsrDataW    = 32;
   localparam int DigitsW     = 3;
   localparam int CodesW      = 4;
   localparam int BlockW      = 64;
   localparam int QueueDepth  = 2;
   localparam int ModWidthDef = 32;
   localparam int ExpWidthDef = 32;

   localparam logic [CsrDataW-1:0] ExponentReset = 32'd65537;
   localparam logic [CsrDataW-1:0] ModulusReset  = 32'd143;
   localparam logic [DigitsW-1:0]  DigitsReset   = 3'd1;
   localparam logic [CodesW-1:0]   CodesReset    = 4'd1;

   typedef enum logic [1:0] {
      CSR_EXPONENT,
      CSR_MODULUS,
      CSR_DIGITS,
      CSR_CODES
   } csr_index_type;

   typedef struct packed {
      logic [DigitsW-1:0] digits;
      logic [CodesW-1:0]  codes;
   } pack_cfg_type;

   typedef struct packed {
      logic              valid;
      logic [BlockW-1:0] block;
   } blk_beat_type;

endpackage

>>> rtl/core/rbpe_req_if.sv
// Input channel: one code point per beat.
interface rbpe_req_if
   import rbpe_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [CodeW-1:0] code_point;

   modport source (output valid, output code_point, input ready);
   modport sink (input valid, input code_point, output ready);
endinterface

>>> rtl/core/rbpe_rsp_if.sv
// Result channel: one cipher block per beat.
interface rbpe_rsp_if
   import rbpe_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [CipherW-1:0] cipher_block;
   logic               block_too_large;

   modport source (output valid, output cipher_block, output block_too_large, input ready);
   modport sink (input valid, input cipher_block, input block_too_large, output ready);
endinterface

>>> rtl/core/rbpe_csr_if.sv
// Configuration write channel: register index and write data per beat.
interface rbpe_csr_if
   import rbpe_pkg::*;
   ;
   logic                valid;
   logic                ready;
   csr_index_type       index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/rsa_block_packer_encryptor_unit.sv
// Top level of the RSA block packer and encryptor.
//
//   channel   role    beat carries
//   req_bus   sink    code_point
//   rsp_bus   source  cipher_block, block_too_large
//   csr_bus   sink    index, data (always ready)
//
// Packing: x10 per digit, then add the code point; a finished block waits for queue room.
// Encryption: take a block, reduce it bit by bit modulo the modulus, then per exponent bit
// (most significant first) square the running value by shift-and-add and, when the bit is
// set, multiply it by the reduced block in the same way; the result beat holds until taken.
// A two-entry block queue lets packing run on while a block encrypts. Reset is synchronous;
// no clearing pass follows.
module rsa_block_packer_encryptor_unit
   import rbpe_pkg::*;
#(
   parameter int MOD_WIDTH = ModWidthDef,
   parameter int EXP_WIDTH = ExpWidthDef
) (
   input  logic       clock,
   input  logic       reset,
   rbpe_req_if.sink   req_bus,
   rbpe_rsp_if.source rsp_bus,
   rbpe_csr_if.sink   csr_bus
);

   logic [EXP_WIDTH-1:0] exponent_ff;
   logic [MOD_WIDTH-1:0] modulus_ff;
   pack_cfg_type         pack_cfg_ff;

   blk_beat_type push;
   blk_beat_type head;
   logic         q_full;
   logic         pop;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff        <= EXP_WIDTH'(ExponentReset);
         modulus_ff         <= MOD_WIDTH'(ModulusReset);
         pack_cfg_ff.digits <= DigitsReset;
         pack_cfg_ff.codes  <= CodesReset;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_EXPONENT: exponent_ff        <= EXP_WIDTH'(csr_bus.data);
            CSR_MODULUS:  modulus_ff         <= MOD_WIDTH'(csr_bus.data);
            CSR_DIGITS:   pack_cfg_ff.digits <= csr_bus.data[DigitsW-1:0];
            CSR_CODES:    pack_cfg_ff.codes  <= csr_bus.data[CodesW-1:0];
            default: ;
         endcase
      end
   end

   rbpe_front u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (pack_cfg_ff),
      .req_bus (req_bus),
      .q_full  (q_full),
      .push    (push)
   );

   rbpe_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   rbpe_modexp #(
      .MOD_WIDTH (MOD_WIDTH),
      .EXP_WIDTH (EXP_WIDTH)
   ) u_modexp (
      .clock    (clock),
      .reset    (reset),
      .modulus  (modulus_ff),
      .exponent (exponent_ff),
      .head     (head),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule

>>> rtl/core/rbpe_front.sv
// Front end: accepts code points and packs them into decimal blocks.
module rbpe_front
   import rbpe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pack_cfg_type cfg,
   rbpe_req_if.sink     req_bus,
   input  logic         q_full,
   output blk_beat_type push
);

   typedef enum logic [1:0] {
      F_IDLE,
      F_SCALE,
      F_ADD
   } front_state_type;

   front_state_type     state_ff;
   logic [BlockW-1:0]   acc_ff;
   logic [CodesW-1:0]   count_ff;
   logic [CodeW-1:0]    cp_ff;
   logic [DigitsW-1:0]  scale_ff;

   logic [BlockW-1:0]   acc_times10;
   logic [BlockW-1:0]   acc_sum_in;
   logic [CodesW-1:0]   count_in;
   logic [CodesW-1:0]   target;
   logic                complete;

   assign acc_times10 = (acc_ff << 3) + (acc_ff << 1);
   assign acc_sum_in  = acc_ff + BlockW'(cp_ff);
   assign count_in    = count_ff + CodesW'(1);
   assign target      = (cfg.codes == '0) ? CodesW'(1) : cfg.codes;
   assign complete    = (count_in >= target);

   assign req_bus.ready = (state_ff == F_IDLE);
   assign push.valid    = (state_ff == F_ADD) && complete && !q_full;
   assign push.block    = acc_sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         acc_ff   <= '0;
         count_ff <= '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_bus.valid) begin
                  cp_ff    <= req_bus.code_point;
                  scale_ff <= cfg.digits;
                  state_ff <= (cfg.digits == '0) ? F_ADD : F_SCALE;
               end
            end
            F_SCALE: begin
               acc_ff   <= acc_times10;
               scale_ff <= scale_ff - DigitsW'(1);
               if (scale_ff == DigitsW'(1)) begin
                  state_ff <= F_ADD;
               end
            end
            F_ADD: begin
               if (!complete) begin
                  acc_ff   <= acc_sum_in;
                  count_ff <= count_in;
                  state_ff <= F_IDLE;
               end else if (!q_full) begin
                  acc_ff   <= '0;
                  count_ff <= '0;
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

>>> rtl/core/rbpe_queue.sv
// Short block queue between the packer and the exponentiation engine.
module rbpe_queue
   import rbpe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  blk_beat_type push,
   output logic         full,
   output blk_beat_type head,
   input  logic         pop
);

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   logic [BlockW-1:0] entry_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff;
   logic [PtrW-1:0]   rd_ptr_ff;
   logic [CntW-1:0]   count_ff;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == CntW'(QueueDepth));
   assign head.valid = (count_ff != '0);
   assign head.block = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.block;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

endmodule

>>> rtl/core/rbpe_modexp.sv
// Back end: block reduction and square-and-multiply modular exponentiation.
module rbpe_modexp
   import rbpe_pkg::*;
#(
   parameter int MOD_WIDTH = ModWidthDef,
   parameter int EXP_WIDTH = ExpWidthDef
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [MOD_WIDTH-1:0] modulus,
   input  logic [EXP_WIDTH-1:0] exponent,
   input  blk_beat_type         head,
   output logic                 pop,
   rbpe_rsp_if.source           rsp_bus
);

   localparam int RedW = $clog2(BlockW);
   localparam int BitW = $clog2(MOD_WIDTH);
   localparam int EidW = $clog2(EXP_WIDTH);

   typedef enum logic [2:0] {
      B_IDLE,
      B_REDUCE,
      B_DBL,
      B_ADD,
      B_OUT
   } back_state_type;

   back_state_type       state_ff;
   logic [BlockW-1:0]    shreg_ff;
   logic [MOD_WIDTH-1:0] rem_ff;
   logic [RedW-1:0]      red_cnt_ff;
   logic [MOD_WIDTH-1:0] base_ff;
   logic [MOD_WIDTH-1:0] mm_a_ff;
   logic [MOD_WIDTH-1:0] mm_b_ff;
   logic [MOD_WIDTH-1:0] acc_ff;
   logic [BitW-1:0]      bit_ff;
   logic [EidW-1:0]      eidx_ff;
   logic                 is_mul_ff;
   logic [MOD_WIDTH-1:0] res_ff;
   logic                 too_large_ff;

   logic [MOD_WIDTH:0]   red_t;
   logic [MOD_WIDTH:0]   red_diff;
   logic [MOD_WIDTH-1:0] red_in;
   logic [MOD_WIDTH-1:0] r_init;
   logic [MOD_WIDTH-1:0] dbl_sum;
   logic [MOD_WIDTH-1:0] add_sum;
   logic [MOD_WIDTH-1:0] mm_val;
   logic                 mm_done;

   function automatic logic [MOD_WIDTH-1:0] add_mod(input logic [MOD_WIDTH-1:0] x,
                                                    input logic [MOD_WIDTH-1:0] y,
                                                    input logic [MOD_WIDTH-1:0] n);
      logic [MOD_WIDTH:0] s;
      logic [MOD_WIDTH:0] d;
      s = {1'b0, x} + {1'b0, y};
      d = s - {1'b0, n};
      return (s >= {1'b0, n}) ? d[MOD_WIDTH-1:0] : s[MOD_WIDTH-1:0];
   endfunction

   assign red_t    = {rem_ff, shreg_ff[BlockW-1]};
   assign red_diff = red_t - {1'b0, modulus};
   assign red_in   = (red_t >= {1'b0, modulus}) ? red_diff[MOD_WIDTH-1:0]
                                                  : red_t[MOD_WIDTH-1:0];
   assign r_init   = (modulus == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
   assign dbl_sum  = add_mod(acc_ff, acc_ff, modulus);
   assign add_sum  = add_mod(acc_ff, mm_a_ff, modulus);
   assign mm_val   = (state_ff == B_ADD) ? add_sum : dbl_sum;
   assign mm_done  = (bit_ff == '0) &&
                     ((state_ff == B_ADD) || ((state_ff == B_DBL) && !mm_b_ff[bit_ff]));

   assign pop                     = (state_ff == B_IDLE) && head.valid;
   assign rsp_bus.valid           = (state_ff == B_OUT);
   assign rsp_bus.cipher_block    = CipherW'(res_ff);
   assign rsp_bus.block_too_large = too_large_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         unique case (state_ff)
            B_IDLE: begin
               if (head.valid) begin
                  shreg_ff     <= head.block;
                  too_large_ff <= (head.block >= BlockW'(modulus));
                  rem_ff       <= '0;
                  red_cnt_ff   <= '1;
                  if (modulus == '0) begin
                     res_ff   <= '0;
                     state_ff <= B_OUT;
                  end else begin
                     state_ff <= B_REDUCE;
                  end
               end
            end
            B_REDUCE: begin
               rem_ff   <= red_in;
               shreg_ff <= shreg_ff << 1;
               if (red_cnt_ff == '0) begin
                  base_ff   <= red_in;
                  mm_a_ff   <= r_init;
                  mm_b_ff   <= r_init;
                  acc_ff    <= '0;
                  bit_ff    <= BitW'(MOD_WIDTH - 1);
                  eidx_ff   <= EidW'(EXP_WIDTH - 1);
                  is_mul_ff <= 1'b0;
                  state_ff  <= B_DBL;
               end else begin
                  red_cnt_ff <= red_cnt_ff - RedW'(1);
               end
            end
            B_DBL, B_ADD: begin
               if (mm_done) begin
                  acc_ff <= '0;
                  bit_ff <= BitW'(MOD_WIDTH - 1);
                  if (!is_mul_ff && exponent[eidx_ff]) begin
                     mm_a_ff   <= mm_val;
                     mm_b_ff   <= base_ff;
                     is_mul_ff <= 1'b1;
                     state_ff  <= B_DBL;
                  end else if (eidx_ff == '0) begin
                     res_ff   <= mm_val;
                     state_ff <= B_OUT;
                  end else begin
                     eidx_ff   <= eidx_ff - EidW'(1);
                     mm_a_ff   <= mm_val;
                     mm_b_ff   <= mm_val;
                     is_mul_ff <= 1'b0;
                     state_ff  <= B_DBL;
                  end
               end else if (state_ff == B_DBL) begin
                  acc_ff <= dbl_sum;
                  if (mm_b_ff[bit_ff]) begin
                     state_ff <= B_ADD;
                  end else begin
                     bit_ff <= bit_ff - BitW'(1);
                  end
               end else begin
                  acc_ff   <= add_sum;
                  bit_ff   <= bit_ff - BitW'(1);
                  state_ff <= B_DBL;
               end
            end
            B_OUT: begin
               if (rsp_bus.ready) begin
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule
